[hdl/mtsat_pkg.sv]
// Shared types and constants of the MAC48 / short address translation table.
// No dependencies; imported by mtsat_scan, the top level and the checker.
package mtsat_pkg;

   localparam int MAC_W     = 48;
   localparam int SHORT_W   = 8;
   localparam int TYPE_W    = 2;
   localparam int PAIR_W    = MAC_W + SHORT_W;
   localparam int IDX_MAX_W = 8;   // table depth at most 256

   localparam logic [MAC_W-1:0]   BCAST_MAC   = {MAC_W{1'b1}};
   localparam logic [SHORT_W-1:0] BCAST_SHORT = {SHORT_W{1'b1}};

   // request kinds
   localparam logic [TYPE_W-1:0] REQ_FWD  = 2'd0;
   localparam logic [TYPE_W-1:0] REQ_REV  = 2'd1;
   localparam logic [TYPE_W-1:0] REQ_DEL  = 2'd2;
   localparam logic [TYPE_W-1:0] REQ_NONE = 2'd3;

   // response flag positions in rsp_tuser
   localparam int FLAG_NEW  = 0;
   localparam int FLAG_FULL = 1;
   localparam int FLAG_DEL  = 2;
   localparam int FLAG_W    = 3;

   // outcome of one sweep over the table
   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic [MAC_W-1:0]     hit_mac;
      logic [SHORT_W-1:0]   hit_short;
      logic                 free_found;
      logic [IDX_MAX_W-1:0] free_idx;
   } scan_status_type;

endpackage

[hdl/mtsat_ram.sv]
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module mtsat_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic                                         rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;
endmodule

[hdl/mtsat_scan.sv]
// Match and free-slot tracker fed by the table sweep, one entry per cycle.
// Depends on mtsat_pkg.
module mtsat_scan #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic                                                     clock,
   input  logic                                                     reset,
   input  logic                                                     start,
   input  logic                                                     rd_pend,
   input  logic [((TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1)-1:0] rd_idx,
   input  logic [mtsat_pkg::MAC_W-1:0]                              rd_mac,
   input  logic [mtsat_pkg::SHORT_W-1:0]                            rd_short,
   input  logic                                                     rd_entry_valid,
   input  logic                                                     match_short,
   input  logic [mtsat_pkg::MAC_W-1:0]                              key_mac,
   input  logic [mtsat_pkg::SHORT_W-1:0]                            key_short,
   output mtsat_pkg::scan_status_type                               status
);
   import mtsat_pkg::*;

   scan_status_type status_ff;
   scan_status_type status_in;
   logic            key_eq;

   assign key_eq = match_short ? (rd_short == key_short) : (rd_mac == key_mac);

   always_comb begin
      status_in = status_ff;
      if (start) begin
         status_in.hit        = 1'b0;
         status_in.free_found = 1'b0;
      end else if (rd_pend) begin
         // lowest index wins for both the match and the free slot
         if (rd_entry_valid && key_eq && !status_ff.hit) begin
            status_in.hit       = 1'b1;
            status_in.hit_idx   = IDX_MAX_W'(rd_idx);
            status_in.hit_mac   = rd_mac;
            status_in.hit_short = rd_short;
         end
         if (!rd_entry_valid && !status_ff.free_found) begin
            status_in.free_found = 1'b1;
            status_in.free_idx   = IDX_MAX_W'(rd_idx);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         status_ff.hit        <= 1'b0;
         status_ff.free_found <= 1'b0;
      end else begin
         status_ff.hit        <= status_in.hit;
         status_ff.free_found <= status_in.free_found;
      end
      status_ff.hit_idx   <= status_in.hit_idx;
      status_ff.hit_mac   <= status_in.hit_mac;
      status_ff.hit_short <= status_in.hit_short;
      status_ff.free_idx  <= status_in.free_idx;
   end

   assign status = status_ff;
endmodule

[hdl/mac48_to_short_address_table_top.sv]
// Top level of the MAC48 / short address translation table.
// Depends on mtsat_pkg, mtsat_ram and mtsat_scan.
//
// Usage:
//   req channel: one request per handshake. req_tuser holds the request kind
//   (forward MAC to short, reverse short to MAC, remove MAC); req_tdata holds
//   the MAC and the short address. rsp channel: exactly one response per
//   request, in order. rsp_tdata holds the short and MAC results, rsp_tuser
//   the newly-allocated, table-full and entry-removed flags.
//   Pairs live in one RAM of TABLE_DEPTH entries; valid bits are flip-flops.
//   Each request that is not a broadcast or unused-kind request sweeps the
//   whole RAM through its single read port, one entry per cycle, then commits
//   at most one write; broadcast and unused-kind requests skip the sweep and
//   go straight to their commit. One request is in work at a time.
//   Reset clears all valid bits and both allocation counters at once; no
//   clearing pass is needed. When rsp_tready is low the finished response
//   waits in the output register; the block still accepts the next request
//   and holds its commit until the output register frees up.
module mac48_to_short_address_table_top #(
   parameter int TABLE_DEPTH = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // [47:0] mac_addr, [55:48] short_addr
   input  logic [1:0]  req_tuser,   // [1:0] req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [7:0] short_result, [55:8] mac_result
   output logic [2:0]  rsp_tuser    // [0] newly_allocated, [1] table_full,
                                    // [2] entry_removed
);
   import mtsat_pkg::*;

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [TYPE_W-1:0]      req_type_ff;
   logic [MAC_W-1:0]       key_mac_ff;
   logic [SHORT_W-1:0]     key_short_ff;
   logic [IDX_W-1:0]       addr_ff;
   logic                   rd_pend_ff;
   logic [IDX_W-1:0]       rd_idx_ff;
   logic [TABLE_DEPTH-1:0] entry_valid_ff;
   logic [SHORT_W-1:0]     next_short_ff, next_short_in;
   logic [MAC_W-1:0]       next_mac_ff, next_mac_in;
   logic                   rsp_valid_ff;
   logic [SHORT_W-1:0]     rsp_short_ff;
   logic [MAC_W-1:0]       rsp_mac_ff;
   logic [FLAG_W-1:0]      rsp_flags_ff;

   logic                   accept;
   logic                   bypass;
   logic                   commit;
   logic [MAC_W-1:0]       in_mac;
   logic [SHORT_W-1:0]     in_short;
   logic [PAIR_W-1:0]      rd_pair;
   scan_status_type        status;
   logic [IDX_W-1:0]       hit_idx;
   logic [IDX_W-1:0]       free_idx;
   logic [MAC_W-1:0]       mac_inc;
   logic [MAC_W-1:0]       mac_alloc;
   logic [SHORT_W-1:0]     short_after;

   logic                   wr_en;
   logic [PAIR_W-1:0]      wr_data;
   logic                   set_valid;
   logic                   clr_valid;
   logic [SHORT_W-1:0]     res_short;
   logic [MAC_W-1:0]       res_mac;
   logic [FLAG_W-1:0]      res_flags;

   assign in_mac   = req_tdata[MAC_W-1:0];
   assign in_short = req_tdata[PAIR_W-1:MAC_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign commit     = (state_ff == ST_FINISH) && (!rsp_valid_ff || rsp_tready);

   // broadcast and unused requests need no table sweep
   assign bypass = ((req_tuser == REQ_FWD) && (in_mac == BCAST_MAC))
                || ((req_tuser == REQ_REV) && (in_short == BCAST_SHORT))
                || (req_tuser == REQ_NONE);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:   if (accept) state_in = bypass ? ST_FINISH : ST_SCAN;
         ST_SCAN:   if (addr_ff == LAST_IDX) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_FINISH;
         ST_FINISH: if (commit) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         addr_ff    <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         rd_pend_ff <= (state_ff == ST_SCAN);
         if (state_ff == ST_SCAN) begin
            addr_ff <= (addr_ff == LAST_IDX) ? '0 : addr_ff + 1'b1;
         end
      end
      rd_idx_ff <= addr_ff;
      if (accept) begin
         req_type_ff  <= req_tuser;
         key_mac_ff   <= in_mac;
         key_short_ff <= in_short;
      end
   end

   mtsat_ram #(
      .WIDTH (PAIR_W),
      .DEPTH (TABLE_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (commit && wr_en),
      .wr_addr (free_idx),
      .wr_data (wr_data),
      .rd_en   (state_ff == ST_SCAN),
      .rd_addr (addr_ff),
      .rd_data (rd_pair)
   );

   mtsat_scan #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_scan (
      .clock          (clock),
      .reset          (reset),
      .start          (accept),
      .rd_pend        (rd_pend_ff),
      .rd_idx         (rd_idx_ff),
      .rd_mac         (rd_pair[PAIR_W-1:SHORT_W]),
      .rd_short       (rd_pair[SHORT_W-1:0]),
      .rd_entry_valid (entry_valid_ff[rd_idx_ff]),
      .match_short    (req_type_ff == REQ_REV),
      .key_mac        (key_mac_ff),
      .key_short      (key_short_ff),
      .status         (status)
   );

   assign hit_idx  = status.hit_idx[IDX_W-1:0];
   assign free_idx = status.free_idx[IDX_W-1:0];

   // allocation counters: short skips broadcast by wrapping at 254,
   // MAC advances first and folds broadcast to zero
   assign short_after = (next_short_ff == BCAST_SHORT - 1'b1) ? '0 : next_short_ff + 1'b1;
   assign mac_inc     = next_mac_ff + 1'b1;
   assign mac_alloc   = (mac_inc == BCAST_MAC) ? '0 : mac_inc;

   always_comb begin
      wr_en         = 1'b0;
      wr_data       = {key_mac_ff, next_short_ff};
      set_valid     = 1'b0;
      clr_valid     = 1'b0;
      res_short     = '0;
      res_mac       = '0;
      res_flags     = '0;
      next_short_in = next_short_ff;
      next_mac_in   = next_mac_ff;
      unique case (req_type_ff)
         REQ_FWD: begin
            priority if (key_mac_ff == BCAST_MAC) begin
               res_short = BCAST_SHORT;
            end else if (status.hit) begin
               res_short = status.hit_short;
            end else if (!status.free_found) begin
               res_flags[FLAG_FULL] = 1'b1;
            end else begin
               wr_en               = 1'b1;
               set_valid           = 1'b1;
               res_short           = next_short_ff;
               res_flags[FLAG_NEW] = 1'b1;
               next_short_in       = short_after;
            end
         end
         REQ_REV: begin
            priority if (key_short_ff == BCAST_SHORT) begin
               res_mac = BCAST_MAC;
            end else if (status.hit) begin
               res_mac = status.hit_mac;
            end else if (!status.free_found) begin
               res_flags[FLAG_FULL] = 1'b1;
            end else begin
               wr_en               = 1'b1;
               wr_data             = {mac_alloc, key_short_ff};
               set_valid           = 1'b1;
               res_mac             = mac_alloc;
               res_flags[FLAG_NEW] = 1'b1;
               next_mac_in         = mac_alloc;
            end
         end
         REQ_DEL: begin
            if (status.hit) begin
               clr_valid           = 1'b1;
               res_flags[FLAG_DEL] = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= '0;
         next_short_ff  <= '0;
         next_mac_ff    <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (commit) begin
            next_short_ff <= next_short_in;
            next_mac_ff   <= next_mac_in;
            if (set_valid) entry_valid_ff[free_idx] <= 1'b1;
            if (clr_valid) entry_valid_ff[hit_idx]  <= 1'b0;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (commit) begin
         rsp_short_ff <= res_short;
         rsp_mac_ff   <= res_mac;
         rsp_flags_ff <= res_flags;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_mac_ff, rsp_short_ff};
   assign rsp_tuser  = rsp_flags_ff;
endmodule

[hdl/mtsat_checker.sv]
// Port-level checks of the translation table top, attached by bind.
// Depends on mtsat_pkg and mac48_to_short_address_table_top.
module mtsat_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic [55:0] req_tdata,
   input logic [1:0]  req_tuser,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser
);
   import mtsat_pkg::*;

   logic [1:0] pend_ff;
   logic       req_acc;
   logic       rsp_acc;

   assign req_acc = req_tvalid && req_tready;
   assign rsp_acc = rsp_tvalid && rsp_tready;

   // requests accepted but not yet answered
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff <= '0;
      end else begin
         pend_ff <= pend_ff + {1'b0, req_acc} - {1'b0, rsp_acc};
      end
   end

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled request result changed");

   a_one_in_work: assert property (@(posedge clock) disable iff (reset)
      req_acc |=> !req_tready)
      else $error("second request taken while one is in work");

   a_no_orphan: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> pend_ff != 2'd0)
      else $error("result without a pending request");

   a_flags_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tuser))
      else $error("more than one result flag set");

   a_full_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[FLAG_FULL] |-> rsp_tdata == '0)
      else $error("table-full result carries data");
endmodule

bind mac48_to_short_address_table_top mtsat_checker u_mtsat_checker (.*);
